>>> hw/rtl/spcd_pkg.sv
package spcd_pkg;

  localparam int unsigned PaletteSize = 256;
  localparam int unsigned IdxW        = 9;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned PtrW        = $clog2(FifoDepth);
  localparam int unsigned CntW        = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_TRUNC = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       palette_format;
    logic       chunk_start;
    logic       chunk_end;
  } byte_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] color_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

>>> hw/rtl/spcd_if.sv
interface spcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       palette_format;
  logic       chunk_start;
  logic       chunk_end;

  modport source (output valid, output data_byte, output palette_format,
                  output chunk_start, output chunk_end, input ready);
  modport sink   (input valid, input data_byte, input palette_format,
                  input chunk_start, input chunk_end, output ready);
endinterface

interface spcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] color_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       run_last;

  modport source (output valid, output result_kind, output color_index, output red,
                  output green, output blue, output run_last, input ready);
  modport sink   (input valid, input result_kind, input color_index, input red,
                  input green, input blue, input run_last, output ready);
endinterface

>>> hw/rtl/spcd_parse.sv
module spcd_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  spcd_pkg::byte_t byte_i,
  output spcd_pkg::push_t push_o
);
  import spcd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_OLD_COUNT, PH_OLD_SKIP, PH_OLD_NUM, PH_OLD_RGB,
    PH_NEW_HEAD, PH_NEW_ENTRY, PH_NEW_NAMELEN, PH_NEW_NAME, PH_COMPLETE
  } phase_e;

  localparam logic [IdxW-1:0] PalLimit = IdxW'(PaletteSize);

  phase_e           phase_q, phase_d, cur_phase;
  logic [4:0]       pos_q, pos_d, cur_pos;
  logic [15:0]      packets_q, packets_d, cur_packets, packets_dec;
  logic [8:0]       colors_q, colors_d, cur_colors, colors_dec;
  logic [IdxW-1:0]  index_q, index_d, cur_index, index_inc;
  logic [7:0]       range_lo_q, range_lo_d, cur_range_lo;
  logic             range_big_q, range_big_d, cur_range_big;
  logic [7:0]       gather_q, gather_d, cur_gather;
  logic             first_big_q, first_big_d, cur_first_big, first_big_n;
  logic [15:0]      name_q, name_d, cur_name, name_dec;
  logic             has_name_q, has_name_d, cur_has_name;
  logic [7:0]       red_q, red_d, cur_red;
  logic [7:0]       green_q, green_d, cur_green;
  logic [IdxW:0]    skip_sum;
  logic             index_ok, next_ok;
  logic             wr, fin;
  res_t             wr_res, fin_res;
  logic [7:0]       b;

  assign b = byte_i.data_byte;

  always_comb begin
    if (byte_i.chunk_start) begin
      cur_phase     = byte_i.palette_format ? PH_NEW_HEAD : PH_OLD_COUNT;
      cur_pos       = '0;
      cur_packets   = '0;
      cur_colors    = '0;
      cur_index     = '0;
      cur_range_lo  = '0;
      cur_range_big = 1'b0;
      cur_gather    = '0;
      cur_first_big = 1'b0;
      cur_name      = '0;
      cur_has_name  = 1'b0;
      cur_red       = '0;
      cur_green     = '0;
    end else begin
      cur_phase     = phase_q;
      cur_pos       = pos_q;
      cur_packets   = packets_q;
      cur_colors    = colors_q;
      cur_index     = index_q;
      cur_range_lo  = range_lo_q;
      cur_range_big = range_big_q;
      cur_gather    = gather_q;
      cur_first_big = first_big_q;
      cur_name      = name_q;
      cur_has_name  = has_name_q;
      cur_red       = red_q;
      cur_green     = green_q;
    end
  end

  assign packets_dec = cur_packets - 16'd1;
  assign colors_dec  = cur_colors - 9'd1;
  assign index_inc   = cur_index + IdxW'(1);
  assign name_dec    = cur_name - 16'd1;
  assign skip_sum    = {1'b0, cur_index} + (IdxW + 1)'(b);
  assign index_ok    = (cur_index < PalLimit) &&
                       (cur_range_big || (cur_index <= {1'b0, cur_range_lo}));
  assign next_ok     = (index_inc < PalLimit) &&
                       (cur_range_big || (index_inc <= {1'b0, cur_range_lo}));
  assign first_big_n = cur_first_big | (b != 8'd0);

  always_comb begin
    phase_d     = cur_phase;
    pos_d       = cur_pos;
    packets_d   = cur_packets;
    colors_d    = cur_colors;
    index_d     = cur_index;
    range_lo_d  = cur_range_lo;
    range_big_d = cur_range_big;
    gather_d    = cur_gather;
    first_big_d = cur_first_big;
    name_d      = cur_name;
    has_name_d  = cur_has_name;
    red_d       = cur_red;
    green_d     = cur_green;
    wr          = 1'b0;
    wr_res      = '{kind: KIND_WRITE, color_index: cur_index[7:0], red: cur_red,
                    green: cur_green, blue: b, run_last: 1'b0};

    case (cur_phase)
      PH_IDLE: begin
      end
      PH_OLD_COUNT: begin
        if (cur_pos == 5'd0) begin
          packets_d = {8'd0, b};
          pos_d     = 5'd1;
        end else begin
          packets_d = {b, cur_packets[7:0]};
          pos_d     = 5'd0;
          phase_d   = ({b, cur_packets[7:0]} != 16'd0) ? PH_OLD_SKIP : PH_COMPLETE;
        end
      end
      PH_OLD_SKIP: begin
        index_d = (skip_sum >= {1'b0, PalLimit}) ? PalLimit : skip_sum[IdxW-1:0];
        phase_d = PH_OLD_NUM;
      end
      PH_OLD_NUM: begin
        colors_d = (b == 8'd0) ? 9'd256 : {1'b0, b};
        pos_d    = 5'd0;
        if (cur_index >= PalLimit) begin
          packets_d = packets_dec;
          phase_d   = (packets_dec != 16'd0) ? PH_OLD_SKIP : PH_COMPLETE;
        end else begin
          phase_d = PH_OLD_RGB;
        end
      end
      PH_OLD_RGB: begin
        case (cur_pos)
          5'd0: begin
            red_d = b;
            pos_d = 5'd1;
          end
          5'd1: begin
            green_d = b;
            pos_d   = 5'd2;
          end
          default: begin
            wr       = 1'b1;
            index_d  = index_inc;
            colors_d = colors_dec;
            pos_d    = 5'd0;
            if ((colors_dec == 9'd0) || (index_inc >= PalLimit)) begin
              packets_d = packets_dec;
              phase_d   = (packets_dec != 16'd0) ? PH_OLD_SKIP : PH_COMPLETE;
            end
          end
        endcase
      end
      PH_NEW_HEAD: begin
        case (cur_pos)
          5'd4: gather_d = b;
          5'd5, 5'd6: first_big_d = first_big_n;
          5'd7: begin
            first_big_d = first_big_n;
            index_d     = (first_big_n || ({1'b0, cur_gather} >= PalLimit)) ?
                          PalLimit : {1'b0, cur_gather};
          end
          5'd8: range_lo_d = b;
          5'd9, 5'd10, 5'd11: range_big_d = cur_range_big | (b != 8'd0);
          default: begin
          end
        endcase
        if (cur_pos >= 5'd19) begin
          pos_d   = 5'd0;
          phase_d = index_ok ? PH_NEW_ENTRY : PH_COMPLETE;
        end else begin
          pos_d = cur_pos + 5'd1;
        end
      end
      PH_NEW_ENTRY: begin
        case (cur_pos)
          5'd0: has_name_d = b[0];
          5'd2: red_d = b;
          5'd3: green_d = b;
          5'd4: gather_d = b;
          default: begin
          end
        endcase
        if (cur_pos >= 5'd5) begin
          wr          = 1'b1;
          wr_res.blue = cur_gather;
          pos_d       = 5'd0;
          if (cur_has_name) begin
            phase_d = PH_NEW_NAMELEN;
          end else begin
            index_d = index_inc;
            phase_d = next_ok ? PH_NEW_ENTRY : PH_COMPLETE;
          end
        end else begin
          pos_d = cur_pos + 5'd1;
        end
      end
      PH_NEW_NAMELEN: begin
        if (cur_pos == 5'd0) begin
          name_d = {8'd0, b};
          pos_d  = 5'd1;
        end else begin
          name_d = {b, cur_name[7:0]};
          pos_d  = 5'd0;
          if ({b, cur_name[7:0]} == 16'd0) begin
            index_d = index_inc;
            phase_d = next_ok ? PH_NEW_ENTRY : PH_COMPLETE;
          end else begin
            phase_d = PH_NEW_NAME;
          end
        end
      end
      PH_NEW_NAME: begin
        name_d = name_dec;
        if (name_dec == 16'd0) begin
          index_d = index_inc;
          pos_d   = 5'd0;
          phase_d = next_ok ? PH_NEW_ENTRY : PH_COMPLETE;
        end
      end
      default: begin
      end
    endcase

    fin     = byte_i.chunk_end && (cur_phase != PH_IDLE);
    fin_res = '{kind: (phase_d == PH_COMPLETE) ? KIND_DONE : KIND_TRUNC,
                color_index: 8'd0, red: 8'd0, green: 8'd0, blue: 8'd0, run_last: 1'b1};
    if (fin) begin
      phase_d = PH_IDLE;
    end
    wr_res.run_last = !fin;
  end

  always_comb begin
    push_o.count  = valid_i ? ({1'b0, wr} + {1'b0, fin}) : 2'd0;
    push_o.first  = wr ? wr_res : fin_res;
    push_o.second = fin_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      packets_q   <= '0;
      colors_q    <= '0;
      index_q     <= '0;
      range_lo_q  <= '0;
      range_big_q <= 1'b0;
      gather_q    <= '0;
      first_big_q <= 1'b0;
      name_q      <= '0;
      has_name_q  <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
    end else if (valid_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      packets_q   <= packets_d;
      colors_q    <= colors_d;
      index_q     <= index_d;
      range_lo_q  <= range_lo_d;
      range_big_q <= range_big_d;
      gather_q    <= gather_d;
      first_big_q <= first_big_d;
      name_q      <= name_d;
      has_name_q  <= has_name_d;
      red_q       <= red_d;
      green_q     <= green_d;
    end
  end

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && fin) |=> (phase_q == PH_IDLE))
    else $error("phase not idle after chunk verdict");

  a_two_means_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (wr && push_o.second.kind != KIND_WRITE))
    else $error("double push without write and verdict");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && wr) |-> (cur_index < PalLimit))
    else $error("palette write beyond palette size");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 5'd19)
    else $error("byte position out of range");

endmodule

>>> hw/rtl/spcd_res_fifo.sv
module spcd_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spcd_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output spcd_pkg::res_t  res_o
);
  import spcd_pkg::*;

  res_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_next;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign wr_ptr_next = wr_ptr_q + PtrW'(1);
  assign valid_o     = (count_q != '0);
  assign pop         = valid_o && ready_i;
  assign room_o      = (count_q <= CntW'(FifoDepth - 2));
  assign res_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("push without room");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(1) && pop && push_i.count == 2'd0) |=> !valid_o)
    else $error("queue not empty after last pop");

endmodule

>>> hw/rtl/sprite_palette_chunk_decoder_top.sv
// A result passes through the input stage register and the result queue before it is offered.
// Throughput: one data byte per cycle while the queue has room; a byte that writes a
// color and ends the chunk puts two results into the four-entry result queue, which
// drains one a cycle while out_o.ready is high. Reset: rst_ni clears the parse state
// to idle and empties the input stage and the queue. No clearing pass follows reset.
module sprite_palette_chunk_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  spcd_in_if.sink           in_i,
  spcd_out_if.source        out_o
);
  import spcd_pkg::*;

  byte_t in_q;
  logic  in_valid_q;
  logic  room;
  logic  fire;
  push_t push;
  res_t  res;

  assign fire       = in_valid_q && room;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= '{data_byte: in_i.data_byte, palette_format: in_i.palette_format,
                chunk_start: in_i.chunk_start, chunk_end: in_i.chunk_end};
    end
  end

  spcd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(fire),
    .byte_i (in_q),
    .push_o (push)
  );

  spcd_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .res_o  (res)
  );

  assign out_o.result_kind = res.kind;
  assign out_o.color_index = res.color_index;
  assign out_o.red         = res.red;
  assign out_o.green       = res.green;
  assign out_o.blue        = res.blue;
  assign out_o.run_last    = res.run_last;

endmodule

>>> tb/sprite_palette_chunk_decoder_top_tb.sv
class palette_scoreboard;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_OLD_COUNT,
    PH_OLD_SKIP,
    PH_OLD_NUM,
    PH_OLD_RGB,
    PH_NEW_HEAD,
    PH_NEW_ENTRY,
    PH_NEW_NAMELEN,
    PH_NEW_NAME,
    PH_COMPLETE
  } phase_e;

  phase_e              phase;
  logic [4:0]          pos;
  logic [15:0]         packets_left;
  logic [8:0]          colors_left;
  logic [8:0]          entry_idx;
  logic [31:0]         last_idx;
  logic [31:0]         word_acc;
  logic [15:0]         name_left;
  logic                has_name;
  logic [15:0]         rg_hold;
  spcd_pkg::res_t      owed_results[$];
  int                  fresh;
  int                  errors;

  function new();
    errors = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    phase        = PH_IDLE;
    pos          = '0;
    packets_left = '0;
    colors_left  = '0;
    entry_idx    = '0;
    last_idx     = '0;
    word_acc     = '0;
    name_left    = '0;
    has_name     = 1'b0;
    rg_hold      = '0;
  endfunction

  function void push_result(spcd_pkg::kind_e kind, logic [7:0] idx, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b);
    spcd_pkg::res_t res;
    res.kind        = kind;
    res.color_index = idx;
    res.red         = r;
    res.green       = g;
    res.blue        = b;
    res.run_last    = 1'b0;
    owed_results.push_back(res);
    fresh++;
  endfunction

  function bit range_open();
    return !entry_idx[8] && ({23'd0, entry_idx} <= last_idx);
  endfunction

  function void packet_done();
    packets_left = packets_left - 16'd1;
    pos          = '0;
    phase        = (packets_left != 0) ? PH_OLD_SKIP : PH_COMPLETE;
  endfunction

  function void next_entry();
    entry_idx = entry_idx + 9'd1;
    pos       = '0;
    phase     = range_open() ? PH_NEW_ENTRY : PH_COMPLETE;
  endfunction

  function void note_byte(spcd_pkg::byte_t t);
    logic [7:0]     b;
    logic [9:0]     sum;
    int             sh;
    spcd_pkg::res_t res;
    b     = t.data_byte;
    fresh = 0;
    if (t.chunk_start) begin
      clear_parse();
      phase = t.palette_format ? PH_NEW_HEAD : PH_OLD_COUNT;
    end
    case (phase)
      PH_IDLE: begin
        return;
      end
      PH_OLD_COUNT: begin
        if (pos == 0) begin
          packets_left = {8'h00, b};
          pos          = 5'd1;
        end else begin
          packets_left[15:8] = b;
          pos                = '0;
          phase              = (packets_left != 0) ? PH_OLD_SKIP : PH_COMPLETE;
        end
      end
      PH_OLD_SKIP: begin
        sum       = {1'b0, entry_idx} + {2'b00, b};
        entry_idx = (sum >= 10'd256) ? 9'd256 : sum[8:0];
        phase     = PH_OLD_NUM;
      end
      PH_OLD_NUM: begin
        colors_left = (b != 0) ? {1'b0, b} : 9'd256;
        if (entry_idx[8]) begin
          packet_done();
        end else begin
          phase = PH_OLD_RGB;
          pos   = '0;
        end
      end
      PH_OLD_RGB: begin
        if (pos == 0) begin
          rg_hold = {8'h00, b};
          pos     = 5'd1;
        end else if (pos == 1) begin
          rg_hold[15:8] = b;
          pos           = 5'd2;
        end else begin
          push_result(spcd_pkg::KIND_WRITE, entry_idx[7:0], rg_hold[7:0], rg_hold[15:8], b);
          entry_idx   = entry_idx + 9'd1;
          colors_left = colors_left - 9'd1;
          pos         = '0;
          if (colors_left == 0 || entry_idx[8]) packet_done();
        end
      end
      PH_NEW_HEAD: begin
        if (pos >= 4 && pos <= 7) begin
          sh              = 8 * (pos - 4);
          word_acc[sh+:8] = b;
          if (pos == 7) entry_idx = (word_acc >= 32'd256) ? 9'd256 : word_acc[8:0];
        end else if (pos >= 8 && pos <= 11) begin
          sh              = 8 * (pos - 8);
          last_idx[sh+:8] = b;
        end
        if (pos >= 19) begin
          pos   = '0;
          phase = range_open() ? PH_NEW_ENTRY : PH_COMPLETE;
        end else begin
          pos = pos + 5'd1;
        end
      end
      PH_NEW_ENTRY: begin
        case (pos)
          5'd0: has_name = b[0];
          5'd2: rg_hold = {8'h00, b};
          5'd3: rg_hold[15:8] = b;
          5'd4: word_acc = {24'h0, b};
          default: ;
        endcase
        if (pos >= 5) begin
          push_result(spcd_pkg::KIND_WRITE, entry_idx[7:0], rg_hold[7:0], rg_hold[15:8],
                      word_acc[7:0]);
          pos = '0;
          if (has_name) phase = PH_NEW_NAMELEN;
          else next_entry();
        end else begin
          pos = pos + 5'd1;
        end
      end
      PH_NEW_NAMELEN: begin
        if (pos == 0) begin
          name_left = {8'h00, b};
          pos       = 5'd1;
        end else begin
          name_left[15:8] = b;
          pos             = '0;
          if (name_left == 0) next_entry();
          else phase = PH_NEW_NAME;
        end
      end
      PH_NEW_NAME: begin
        name_left = name_left - 16'd1;
        if (name_left == 0) next_entry();
      end
      default: ;
    endcase
    if (t.chunk_end) begin
      push_result((phase == PH_COMPLETE) ? spcd_pkg::KIND_DONE : spcd_pkg::KIND_TRUNC,
                  8'h00, 8'h00, 8'h00, 8'h00);
      phase = PH_IDLE;
    end
    if (fresh > 0) begin
      res          = owed_results.pop_back();
      res.run_last = 1'b1;
      owed_results.push_back(res);
    end
  endfunction

  task report(string what, spcd_pkg::res_t got, spcd_pkg::res_t want);
    errors++;
    $display("%0t %s: got %0d/%0d/%h/%h/%h/%b want %0d/%0d/%h/%h/%h/%b", $time, what,
             got.kind, got.color_index, got.red, got.green, got.blue, got.run_last,
             want.kind, want.color_index, want.red, want.green, want.blue, want.run_last);
  endtask

  task check_result(spcd_pkg::res_t got);
    spcd_pkg::res_t want;
    if (owed_results.size() == 0) begin
      report("result with nothing owed", got, '0);
    end else begin
      want = owed_results.pop_front();
      if (got.kind !== want.kind || got.color_index !== want.color_index ||
          got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.run_last !== want.run_last) begin
        report("result mismatch", got, want);
      end
    end
  endtask

  task check_drained();
    if (owed_results.size() != 0) begin
      report($sformatf("%0d results never arrived, first", owed_results.size()), '0,
             owed_results[0]);
    end
  endtask

endclass

module sprite_palette_chunk_decoder_top_tb;
  import spcd_pkg::*;

  localparam int QuietLimit  = 5000;
  localparam int ChunkBytes  = 400;
  localparam int DrainCycles = 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  spcd_in_if  in_if ();
  spcd_out_if out_if ();

  sprite_palette_chunk_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  palette_scoreboard sb;
  byte_t             stream_q[$];
  logic [7:0]        body_q[$];
  int                parsed_bytes;
  int                quiet_cycles;
  int                rx_cycle;
  int                rx_mode;
  int                rx_period;
  int                rx_hold;
  res_t              rx_res;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void add_byte(logic [7:0] b, logic fmt, logic st, logic en);
    byte_t t;
    t.data_byte      = b;
    t.palette_format = fmt;
    t.chunk_start    = st;
    t.chunk_end      = en;
    stream_q.push_back(t);
  endfunction

  // fate: 0 cut short, 1 trailing bytes, 2 cut short and left open, else whole
  function automatic void emit_chunk(logic fmt);
    int len;
    int fate;
    int k;
    len  = body_q.size();
    fate = $urandom_range(0, 9);
    if (fate == 1) begin
      repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(0, 255)));
      len = body_q.size();
    end else if ((fate == 0 || fate == 2) && len > 1) begin
      len = $urandom_range(1, len - 1);
    end
    for (k = 0; k < len; k++) begin
      add_byte(body_q[k], (k == 0) ? fmt : 1'($urandom_range(0, 1)), k == 0,
               (k == len - 1) && fate != 2);
    end
    parsed_bytes += len;
    body_q.delete();
  endfunction

  function automatic void gen_old();
    int packets;
    int shown;
    int idx;
    int skip;
    int num;
    int colors;
    int pick;
    int k;
    pick = $urandom_range(0, 9);
    if (pick == 0) packets = 0;
    else if (pick == 1) packets = $urandom_range(256, 65535);
    else packets = $urandom_range(1, 4);
    body_q.push_back(packets[7:0]);
    body_q.push_back(packets[15:8]);
    idx   = 0;
    shown = (packets > 4) ? 3 : packets;
    for (k = 0; k < shown; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) skip = $urandom_range(200, 255);
      else if (pick == 1) skip = $urandom_range(0, 255);
      else skip = $urandom_range(0, 2);
      idx = (idx + skip > 256) ? 256 : idx + skip;
      if (idx >= 248 && $urandom_range(0, 1) == 1) begin
        num = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 255);
      end else begin
        num = $urandom_range(1, 4);
      end
      colors = (num == 0) ? 256 : num;
      if (colors > 256 - idx) colors = 256 - idx;
      body_q.push_back(skip[7:0]);
      body_q.push_back(num[7:0]);
      repeat (3 * colors) body_q.push_back(8'($urandom_range(0, 255)));
      idx += colors;
    end
    emit_chunk(1'b0);
  endfunction

  function automatic void gen_new();
    logic [31:0] first_ix;
    logic [31:0] last_ix;
    logic [15:0] flags;
    int          pick;
    int          stop;
    int          nlen;
    int          i;
    int          k;
    pick     = $urandom_range(0, 9);
    first_ix = $urandom_range(0, 3);
    last_ix  = first_ix + $urandom_range(0, 3);
    case (pick)
      0: begin
        first_ix = $urandom_range(1, 255);
        last_ix  = $urandom_range(0, first_ix - 1);
      end
      1: begin
        first_ix = $urandom();
        if (first_ix < 256) first_ix += 256;
        last_ix = $urandom();
      end
      2: begin
        first_ix = $urandom_range(252, 255);
        last_ix  = $urandom();
      end
      3: begin
        first_ix = $urandom_range(250, 255);
        last_ix  = 32'hFFFF_FFFF;
      end
      default: ;
    endcase
    for (k = 0; k < 20; k++) begin
      if (k >= 4 && k <= 7) body_q.push_back(first_ix[8*(k-4)+:8]);
      else if (k >= 8 && k <= 11) body_q.push_back(last_ix[8*(k-8)+:8]);
      else body_q.push_back(8'($urandom_range(0, 255)));
    end
    if (first_ix < 256) begin
      stop = (last_ix > 255) ? 255 : int'(last_ix);
      for (i = int'(first_ix); i <= stop; i++) begin
        flags    = 16'($urandom());
        flags[0] = ($urandom_range(0, 2) == 0);
        body_q.push_back(flags[7:0]);
        body_q.push_back(flags[15:8]);
        repeat (4) body_q.push_back(8'($urandom_range(0, 255)));
        if (flags[0]) begin
          nlen = $urandom_range(0, 3);
          body_q.push_back(nlen[7:0]);
          body_q.push_back(8'h00);
          repeat (nlen) body_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    emit_chunk(1'b1);
  endfunction

  function automatic void gen_garbage();
    repeat ($urandom_range(1, 24)) body_q.push_back(8'($urandom_range(0, 255)));
    emit_chunk(1'($urandom_range(0, 1)));
  endfunction

  function automatic void build_directed();
    // idle bytes, one with the end mark, then a one-byte chunk and a two-byte chunk
    add_byte(8'hFF, 1'b1, 1'b0, 1'b1);
    add_byte(8'h00, 1'b0, 1'b0, 1'b0);
    add_byte(8'hA5, 1'b1, 1'b1, 1'b1);
    add_byte(8'h00, 1'b0, 1'b1, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0, 1'b1);
    // color count of zero, last index written on the closing byte
    add_byte(8'h01, 1'b0, 1'b1, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    // saturated skip, then a trailing byte
    add_byte(8'h02, 1'b0, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    add_byte(8'h05, 1'b0, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b0, 1'b1);
    // restart in the middle of a header
    add_byte(8'h11, 1'b1, 1'b1, 1'b0);
    add_byte(8'h22, 1'b1, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0, 1'b1);
  endfunction

  function automatic void build_random();
    int pick;
    parsed_bytes = 0;
    while (parsed_bytes < ChunkBytes) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) gen_old();
      else if (pick < 18) gen_new();
      else gen_garbage();
      if ($urandom_range(0, 4) == 0) begin
        add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                 1'($urandom_range(0, 1)));
      end
    end
  endfunction

  task automatic send_stream();
    int   pos;
    int   burst_left;
    int   gap_left;
    logic took;
    pos        = 0;
    burst_left = $urandom_range(1, 40);
    gap_left   = 0;
    while (pos < stream_q.size()) begin
      @(posedge clk_i);
      took = in_if.valid && in_if.ready;
      if (took) begin
        sb.note_byte(stream_q[pos]);
        pos++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      // hold an offered transaction until it is taken
      if (!in_if.valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pos < stream_q.size()) begin
          in_if.data_byte      <= stream_q[pos].data_byte;
          in_if.palette_format <= stream_q[pos].palette_format;
          in_if.chunk_start    <= stream_q[pos].chunk_start;
          in_if.chunk_end      <= stream_q[pos].chunk_end;
          in_if.valid          <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      rx_res.kind        = kind_e'(out_if.result_kind);
      rx_res.color_index = out_if.color_index;
      rx_res.red         = out_if.red;
      rx_res.green       = out_if.green;
      rx_res.blue        = out_if.blue;
      rx_res.run_last    = out_if.run_last;
      sb.check_result(rx_res);
    end
    if (rx_cycle % 48 == 0) begin
      rx_mode   = $urandom_range(0, 3);
      rx_period = $urandom_range(2, 9);
      rx_hold   = $urandom_range(1, rx_period - 1);
    end
    rx_cycle++;
    case (rx_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= 1'($urandom_range(0, 1));
      2:       out_if.ready <= (rx_cycle % rx_period) >= rx_hold;
      default: out_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("** sprite_palette_chunk_decoder_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb                   = new();
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.data_byte      <= 8'h00;
    in_if.palette_format <= 1'b0;
    in_if.chunk_start    <= 1'b0;
    in_if.chunk_end      <= 1'b0;
    build_directed();
    build_random();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_stream();
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("** sprite_palette_chunk_decoder_top: PASSED **");
    end else begin
      $display("** sprite_palette_chunk_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/spcd_pkg.sv
hw/rtl/spcd_if.sv
hw/rtl/spcd_parse.sv
hw/rtl/spcd_res_fifo.sv
hw/rtl/sprite_palette_chunk_decoder_top.sv
tb/sprite_palette_chunk_decoder_top_tb.sv
